>>> design/tpd_pkg.sv
package tpd_pkg;

	// default parameter values
	localparam int DEF_INDEX_BITS  = 24;
	localparam int DEF_SAMPLE_BITS = 16;

	// result field widths
	localparam int AMP_W   = 16;
	localparam int SNR_W   = 24;
	localparam int POS_W   = 30;
	localparam int SCR_W   = 7;
	localparam int DM_W    = 16;
	localparam int SHIFT_W = 3;
	localparam int GAP_W   = 24;
	localparam int RMS_W   = 16;
	localparam int THR_W   = 16;

	// packed result word, padded to whole bytes
	localparam int OUT_BITS   = AMP_W + SNR_W + 3 * POS_W + SCR_W + DM_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	// largest scrunch shift honored
	localparam int MAX_SHIFT = 6;
	// widest index plus largest shift
	localparam int POS_EXT_W = 32 + MAX_SHIFT;

	// snr saturation limits
	localparam int SNR_HI = 8388607;
	localparam int SNR_LO = -8388608;

	// pulse record queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 3'd0,
		REG_RMS_RECIP = 3'd1,
		REG_MERGE_GAP = 3'd2,
		REG_SCRUNCH   = 3'd3,
		REG_TRIAL_DM  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [THR_W-1:0] threshold;
		logic [RMS_W-1:0]        rms_reciprocal;
		logic [GAP_W-1:0]        merge_gap;
		logic [SHIFT_W-1:0]      scrunch_shift;
		logic [DM_W-1:0]         trial_dm;
	} cfg_t;

	// tracker to queue: how many records this sample pushes
	typedef struct packed {
		logic [1:0] count;
	} push_t;

endpackage

>>> design/tpd_tracker.sv
module tpd_tracker #(
	parameter int INDEX_BITS  = tpd_pkg::DEF_INDEX_BITS,
	parameter int SAMPLE_BITS = tpd_pkg::DEF_SAMPLE_BITS,
	parameter int REC_W       = SAMPLE_BITS + 3 * INDEX_BITS + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tpd_pkg::cfg_t                 cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	input  logic                          in_last,
	input  logic [tpd_pkg::QCNT_W-1:0]    queue_count,
	output tpd_pkg::push_t                push,
	output logic [REC_W-1:0]              rec0,
	output logic [REC_W-1:0]              rec1
);
	import tpd_pkg::*;

	localparam int CMP_W = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 1;
	localparam int GAPC_W = ((INDEX_BITS > GAP_W) ? INDEX_BITS : GAP_W);

	// input register
	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          last_s1;

	// search state
	logic [INDEX_BITS-1:0]         idx_q, start_q, end_q, pidx_q;
	logic signed [SAMPLE_BITS-1:0] peak_q;
	logic                          det_q, seen_q;

	logic [INDEX_BITS-1:0]         start_n, end_n, pidx_n;
	logic signed [SAMPLE_BITS-1:0] peak_n;
	logic                          det_n, seen_n;

	logic advance, above, below, gap_big, gap_emit, fin_emit;
	logic signed [CMP_W-1:0] s_ext, t_ext;
	logic [INDEX_BITS-1:0] gap_diff, fin_end;

	// room for two records keeps the worst case safe
	assign advance  = valid_s1 && (queue_count <= QCNT_W'(QUEUE_DEPTH - 2));
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sample_s1 <= in_sample;
			last_s1   <= in_last;
		end
	end

	assign s_ext    = CMP_W'(sample_s1);
	assign t_ext    = CMP_W'(cfg.threshold);
	assign above    = s_ext > t_ext;
	assign below    = s_ext < t_ext;
	assign gap_diff = idx_q - end_q;
	assign gap_big  = GAPC_W'(gap_diff) > GAPC_W'(cfg.merge_gap);
	assign gap_emit = above && !det_q && seen_q && gap_big;

	always_comb begin
		start_n = start_q;
		end_n   = end_q;
		pidx_n  = pidx_q;
		peak_n  = peak_q;
		det_n   = det_q;
		seen_n  = seen_q;
		if (above && !det_q) begin
			det_n = 1'b1;
			if (gap_emit || !seen_q) begin
				seen_n  = 1'b1;
				start_n = idx_q;
				peak_n  = sample_s1;
				pidx_n  = idx_q;
			end else if (sample_s1 > peak_q) begin
				peak_n = sample_s1;
				pidx_n = idx_q;
			end
		end else if (below && det_q) begin
			end_n = idx_q;
			det_n = 1'b0;
		end else if (det_q && sample_s1 > peak_q) begin
			peak_n = sample_s1;
			pidx_n = idx_q;
		end
	end

	// block end flushes an open pulse, or else a pending one
	assign fin_emit = last_s1 && (det_n || seen_n);
	assign fin_end  = det_n ? idx_q : end_n;

	always_comb begin
		if (gap_emit) begin
			rec0 = {!fin_emit, end_q, pidx_q, start_q, peak_q};
		end else begin
			rec0 = {1'b1, fin_end, pidx_n, start_n, peak_n};
		end
		rec1 = {1'b1, fin_end, pidx_n, start_n, peak_n};
		if (!advance) begin
			push.count = 2'd0;
		end else begin
			push.count = {1'b0, gap_emit} + {1'b0, fin_emit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			start_q <= '0;
			end_q   <= '0;
			pidx_q  <= '0;
			peak_q  <= '0;
			det_q   <= 1'b0;
			seen_q  <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				idx_q   <= '0;
				start_q <= '0;
				end_q   <= '0;
				pidx_q  <= '0;
				peak_q  <= '0;
				det_q   <= 1'b0;
				seen_q  <= 1'b0;
			end else begin
				idx_q   <= idx_q + 1'b1;
				start_q <= start_n;
				end_q   <= end_n;
				pidx_q  <= pidx_n;
				peak_q  <= peak_n;
				det_q   <= det_n;
				seen_q  <= seen_n;
			end
		end
	end

endmodule

>>> design/tpd_queue.sv
module tpd_queue #(
	parameter int REC_W = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tpd_pkg::push_t             push,
	input  logic [REC_W-1:0]           wr0,
	input  logic [REC_W-1:0]           wr1,
	input  logic                       pop,
	output logic [REC_W-1:0]           head,
	output logic [tpd_pkg::QCNT_W-1:0] count
);
	import tpd_pkg::*;

	logic [REC_W-1:0]  mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QCNT_W-1:0] cnt_q;

	assign head  = mem[rp_q];
	assign count = cnt_q;

	// up to two writes, one read per cycle
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wp_q] <= wr0;
		end
		if (push.count == 2'd2) begin
			mem[wp_q + 1'b1] <= wr1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + QPTR_W'(push.count);
			rp_q  <= rp_q + QPTR_W'(pop);
			cnt_q <= cnt_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

endmodule

>>> design/tpd_format.sv
module tpd_format #(
	parameter int INDEX_BITS  = tpd_pkg::DEF_INDEX_BITS,
	parameter int SAMPLE_BITS = tpd_pkg::DEF_SAMPLE_BITS,
	parameter int REC_W       = SAMPLE_BITS + 3 * INDEX_BITS + 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tpd_pkg::cfg_t                  cfg,
	input  logic                           rec_avail,
	input  logic [REC_W-1:0]               rec,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tpd_pkg::OUT_DATA_W-1:0] out_data,
	output logic                           out_last
);
	import tpd_pkg::*;

	localparam int PW = SAMPLE_BITS + RMS_W + 1;
	localparam logic signed [PW-1:0] SAT_HI = PW'(SNR_HI);
	localparam logic signed [PW-1:0] SAT_LO = PW'(SNR_LO);

	logic signed [SAMPLE_BITS-1:0] peak;
	logic [INDEX_BITS-1:0]         r_start, r_pidx, r_end, r_width;
	logic                          r_last;
	logic signed [PW-1:0]          prod, scaled;
	logic [SNR_W-1:0]              snr;
	logic [SHIFT_W-1:0]            sh;
	logic [POS_EXT_W-1:0]          start_x, pidx_x, width_x;
	logic [SCR_W-1:0]              scr;
	logic [AMP_W-1:0]              amp;
	logic                          valid_q;

	assign {r_last, r_end, r_pidx, r_start, peak} = rec;
	assign r_width = r_end - r_start;

	// snr = floor(peak * rms / 256), saturated
	assign prod   = PW'(peak) * $signed({1'b0, cfg.rms_reciprocal});
	assign scaled = prod >>> 8;
	always_comb begin
		if (scaled > SAT_HI) begin
			snr = SAT_HI[SNR_W-1:0];
		end else if (scaled < SAT_LO) begin
			snr = SAT_LO[SNR_W-1:0];
		end else begin
			snr = scaled[SNR_W-1:0];
		end
	end

	assign sh      = (cfg.scrunch_shift > SHIFT_W'(MAX_SHIFT)) ?
		SHIFT_W'(MAX_SHIFT) : cfg.scrunch_shift;
	assign start_x = POS_EXT_W'(r_start) << sh;
	assign pidx_x  = POS_EXT_W'(r_pidx) << sh;
	assign width_x = POS_EXT_W'(r_width) << sh;
	assign scr     = SCR_W'(1) << sh;
	// low 16 bits of the peak, sign-extended when samples are narrower
	assign amp     = AMP_W'(peak);

	assign pop       = rec_avail && (!valid_q || out_ready);
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= rec_avail;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data <= OUT_DATA_W'({cfg.trial_dm, scr, width_x[POS_W-1:0],
				pidx_x[POS_W-1:0], start_x[POS_W-1:0], snr, amp});
			out_last <= r_last;
		end
	end

endmodule

>>> design/threshold_pulse_detector.sv
// Threshold pulse detector: streaming single-pulse search over a block of
// signed samples.
// Input stream: s_tdata carries one sample per request, s_tlast marks the
// final sample of a block. Runs strictly above threshold are tracked; runs
// separated by at most merge_gap samples merge into one pulse.
// Output stream: one request per pulse, m_tlast set on the last result a
// given sample caused (a sample can cause two: one closed by a new run and
// one flushed at block end).
// Throughput: one sample per cycle, sustained, while two queue slots are free.
// A result passes from the tracker's input register through the pulse queue
// into the output register behind m_tvalid; a second result from the same sample follows it.
// A four-entry pulse queue sits between the tracker and the output register;
// the tracker's input register holds a sample while fewer than two queue
// slots are free, so a stalled receiver back-pressures s_tready after the
// queue fills. No result is dropped.
// Reset clears search state, queue and output valid, and loads the register
// defaults (threshold 0, rms_reciprocal 1.0, merge_gap 0, shift 0, dm 0).
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once and
// are meant for idle periods; unknown indexes are ignored.
module threshold_pulse_detector #(
	parameter int INDEX_BITS  = tpd_pkg::DEF_INDEX_BITS,
	parameter int SAMPLE_BITS = tpd_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write port
	input  logic                                cfg_we,
	input  logic [tpd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tpd_pkg::CFG_DATA_W-1:0]      cfg_data,
	// sample stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // sample
	input  logic                                s_tlast,  // last_sample
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// peak_amplitude, snr, start_bin, peak_bin, pulse_width,
	// scrunch_factor, pulse_dm, then zero pad
	output logic [tpd_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic                                m_tlast   // last_result
);
	import tpd_pkg::*;

	localparam int REC_W = SAMPLE_BITS + 3 * INDEX_BITS + 1;

	cfg_t              cfg_q;
	push_t             push;
	logic [REC_W-1:0]  rec0, rec1, head;
	logic [QCNT_W-1:0] q_count;
	logic              pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold      <= '0;
			cfg_q.rms_reciprocal <= RMS_W'(256);
			cfg_q.merge_gap      <= '0;
			cfg_q.scrunch_shift  <= '0;
			cfg_q.trial_dm       <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD: begin
					cfg_q.threshold <= cfg_data[THR_W-1:0];
				end
				REG_RMS_RECIP: begin
					cfg_q.rms_reciprocal <= cfg_data[RMS_W-1:0];
				end
				REG_MERGE_GAP: begin
					cfg_q.merge_gap <= cfg_data[GAP_W-1:0];
				end
				REG_SCRUNCH: begin
					cfg_q.scrunch_shift <= cfg_data[SHIFT_W-1:0];
				end
				REG_TRIAL_DM: begin
					cfg_q.trial_dm <= cfg_data[DM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// run tracking, emits pulse records
	tpd_tracker #(
		.INDEX_BITS (INDEX_BITS),
		.SAMPLE_BITS(SAMPLE_BITS),
		.REC_W      (REC_W)
	) u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_sample  (s_tdata[SAMPLE_BITS-1:0]),
		.in_last    (s_tlast),
		.queue_count(q_count),
		.push       (push),
		.rec0       (rec0),
		.rec1       (rec1)
	);

	// pulse record queue
	tpd_queue #(
		.REC_W(REC_W)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr0   (rec0),
		.wr1   (rec1),
		.pop   (pop),
		.head  (head),
		.count (q_count)
	);

	// scaling, snr and output register
	tpd_format #(
		.INDEX_BITS (INDEX_BITS),
		.SAMPLE_BITS(SAMPLE_BITS),
		.REC_W      (REC_W)
	) u_format (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.rec_avail(q_count != '0),
		.rec      (head),
		.pop      (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata),
		.out_last (m_tlast)
	);

`ifndef SYNTHESIS
	// queue never holds more than its depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCNT_W'(QUEUE_DEPTH))
		else $error("pulse queue overflow");

	// pushes only fit into free space
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> q_count <= QCNT_W'(QUEUE_DEPTH - 2))
		else $error("push without room");

	// a pop always leaves the queue one lower unless pushes refill it
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push.count == 2'd0 |=> q_count == $past(q_count) - 1'b1)
		else $error("queue count off after pop");
`endif

endmodule

>>> tb/sv/tpd_pulse_checker.sv
module tpd_pulse_checker
	import tpd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [15:0]           s_tdata,
	input  logic                  s_tlast,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  m_tlast,
	output int                    fail_count,
	output int                    awaiting
);

	localparam int SNR_LSB   = AMP_W;
	localparam int START_LSB = SNR_LSB + SNR_W;
	localparam int PEAK_LSB  = START_LSB + POS_W;
	localparam int WIDTH_LSB = PEAK_LSB + POS_W;
	localparam int SCR_LSB   = WIDTH_LSB + POS_W;
	localparam int DM_LSB    = SCR_LSB + SCR_W;

	typedef struct {
		logic [AMP_W-1:0] amp;
		logic [SNR_W-1:0] snr;
		logic [POS_W-1:0] start_bin;
		logic [POS_W-1:0] peak_bin;
		logic [POS_W-1:0] width;
		logic [SCR_W-1:0] scr;
		logic [DM_W-1:0]  dm;
		logic             last;
	} pulse_rec_t;

	// register copies
	logic signed [THR_W-1:0] thr;
	logic [RMS_W-1:0]        rms;
	logic [GAP_W-1:0]        gap;
	logic [SHIFT_W-1:0]      shift;
	logic [DM_W-1:0]         dm;

	// search state
	logic [23:0]        smp_idx;
	logic               detecting;
	logic               seen;
	logic [23:0]        run_start;
	logic [23:0]        run_end;
	logic signed [15:0] peak;
	logic [23:0]        peak_idx;

	pulse_rec_t pending_pulses[$];
	pulse_rec_t want;

	initial fail_count = 0;
	initial awaiting = 0;

	task automatic clear_search();
		smp_idx   = '0;
		detecting = 1'b0;
		seen      = 1'b0;
		run_start = '0;
		run_end   = '0;
		peak      = '0;
		peak_idx  = '0;
	endtask

	function automatic pulse_rec_t make_pulse(logic [23:0] end_idx);
		pulse_rec_t         r;
		logic signed [40:0] prod;
		logic signed [40:0] q;
		logic [2:0]         sh;
		logic [23:0]        span;
		sh   = (shift > MAX_SHIFT) ? 3'(MAX_SHIFT) : shift;
		prod = peak * $signed({1'b0, rms});
		q    = prod >>> 8;	// floor division by 256
		if (q > SNR_HI)
			q = SNR_HI;
		if (q < SNR_LO)
			q = SNR_LO;
		span        = end_idx - run_start;
		r.amp       = peak;
		r.snr       = q[SNR_W-1:0];
		r.start_bin = POS_W'({8'd0, run_start} << sh);
		r.peak_bin  = POS_W'({8'd0, peak_idx} << sh);
		r.width     = POS_W'({8'd0, span} << sh);
		r.scr       = SCR_W'(1 << sh);
		r.dm        = dm;
		r.last      = 1'b0;
		return r;
	endfunction

	task automatic track_sample(logic signed [15:0] s, logic lst);
		pulse_rec_t  got[2];
		int          n;
		logic [23:0] i;
		logic [23:0] since_end;
		n         = 0;
		i         = smp_idx;
		since_end = i - run_end;
		if (s > thr && !detecting) begin
			detecting = 1'b1;
			if (seen && since_end > gap) begin
				got[n] = make_pulse(run_end);
				n++;
				run_start = i;
				peak      = s;
				peak_idx  = i;
			end else if (seen) begin
				if (s > peak) begin
					peak     = s;
					peak_idx = i;
				end
			end else begin
				seen      = 1'b1;
				run_start = i;
				peak      = s;
				peak_idx  = i;
			end
		end else if (s < thr && detecting) begin
			run_end   = i;
			detecting = 1'b0;
		end else if (detecting && s > peak) begin
			peak     = s;
			peak_idx = i;
		end
		// block end: flush open pulse, else the pending one
		if (lst) begin
			if (detecting) begin
				got[n] = make_pulse(i);
				n++;
			end else if (seen) begin
				got[n] = make_pulse(run_end);
				n++;
			end
			clear_search();
		end else begin
			smp_idx = i + 24'd1;
		end
		for (int k = 0; k < n; k++) begin
			got[k].last = (k == n - 1);
			pending_pulses.insert(pending_pulses.size(), got[k]);
		end
	endtask

	task automatic check_field(string name, logic [29:0] exp_v, logic [29:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr   = '0;
			rms   = 16'd256;
			gap   = '0;
			shift = '0;
			dm    = '0;
			clear_search();
			pending_pulses.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_THRESHOLD: thr   = cfg_data[THR_W-1:0];
					REG_RMS_RECIP: rms   = cfg_data[RMS_W-1:0];
					REG_MERGE_GAP: gap   = cfg_data[GAP_W-1:0];
					REG_SCRUNCH:   shift = cfg_data[SHIFT_W-1:0];
					REG_TRIAL_DM:  dm    = cfg_data[DM_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				track_sample($signed(s_tdata), s_tlast);
			if (m_tvalid && m_tready) begin
				if (pending_pulses.size() == 0) begin
					$error("result with nothing expected: tdata %0h", m_tdata);
					fail_count++;
				end else begin
					want = pending_pulses.pop_front();
					check_field("peak_amplitude", 30'(want.amp),
						30'(m_tdata[0 +: AMP_W]));
					check_field("snr", 30'(want.snr), 30'(m_tdata[SNR_LSB +: SNR_W]));
					check_field("start_bin", want.start_bin, m_tdata[START_LSB +: POS_W]);
					check_field("peak_bin", want.peak_bin, m_tdata[PEAK_LSB +: POS_W]);
					check_field("pulse_width", want.width, m_tdata[WIDTH_LSB +: POS_W]);
					check_field("scrunch_factor", 30'(want.scr),
						30'(m_tdata[SCR_LSB +: SCR_W]));
					check_field("pulse_dm", 30'(want.dm), 30'(m_tdata[DM_LSB +: DM_W]));
					check_field("last_result", 30'(want.last), 30'(m_tlast));
				end
			end
		end
		awaiting = pending_pulses.size();
	end

endmodule

>>> tb/sv/threshold_pulse_detector_tb.sv
// Drives sample blocks into the detector through phases of register settings
// and lets a side checker predict and compare every pulse result.
module threshold_pulse_detector_tb;
	import tpd_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;	// cycles with no request moving
	localparam int FLUSH_CYCLES   = 12;	// covers the pipeline after the last result
	localparam int HOLD_CYCLES    = 300;	// long receiver hold-off
	localparam int N_PHASES       = 10;
	localparam int PHASE_ITEMS    = 95;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [15:0]           s_tdata;	// sample
	logic                  s_tlast;	// last_sample
	logic                  m_tvalid;
	logic                  m_tready;
	// peak_amplitude, snr, start_bin, peak_bin, pulse_width,
	// scrunch_factor, pulse_dm, then zero pad
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;	// last_result

	int fail_count;
	int awaiting;

	int cur_thr;	// threshold now loaded, steers sample choice
	int items_sent;
	int burst_left;
	bit hold_req;	// asks the receiver for one long hold-off

	// receiver pattern state
	int rx_mode;
	int rx_left;

	threshold_pulse_detector u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	tpd_pulse_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.awaiting   (awaiting)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// One sample request. Called and returns at a falling edge. Between bursts
	// the sender drops valid for a random gap.
	task automatic push_sample(int smp, bit lst);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			// mostly short bursts, now and then a long unbroken one
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 20);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= 16'(smp);
		s_tlast  <= lst;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// Stop sending, wait for the last expected result, then let the pipeline
	// drain of samples that produce nothing.
	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (awaiting != 0)
			@(negedge clk);
		repeat (FLUSH_CYCLES) @(negedge clk);
	endtask

	// Writes all five registers on back-to-back cycles; only when idle.
	task automatic write_regs(int thr, int rms, int gap, int sh, int dm);
		cfg_we    <= 1'b1;
		cfg_index <= REG_THRESHOLD;
		cfg_data  <= {8'd0, 16'(thr)};
		@(negedge clk);
		cfg_index <= REG_RMS_RECIP;
		cfg_data  <= CFG_DATA_W'(rms);
		@(negedge clk);
		cfg_index <= REG_MERGE_GAP;
		cfg_data  <= CFG_DATA_W'(gap);
		@(negedge clk);
		cfg_index <= REG_SCRUNCH;
		cfg_data  <= CFG_DATA_W'(sh);
		@(negedge clk);
		cfg_index <= REG_TRIAL_DM;
		cfg_data  <= CFG_DATA_W'(dm);
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_thr = thr;
	endtask

	// kind: 0 above threshold, 1 below, 2 equal, else any 16-bit value
	function automatic int pick_sample(int kind);
		int span;
		case (kind)
			0: begin
				if (cur_thr >= 32767 || $urandom_range(0, 7) == 0)
					return 32767;
				span = 32767 - cur_thr - 1;
				if (span > 400)
					span = 400;
				return cur_thr + 1 + int'($urandom_range(0, span));
			end
			1: begin
				if (cur_thr <= -32768 || $urandom_range(0, 7) == 0)
					return -32768;
				span = cur_thr + 32768 - 1;
				if (span > 400)
					span = 400;
				return cur_thr - 1 - int'($urandom_range(0, span));
			end
			2: return cur_thr;
			default: return int'($signed(16'($urandom)));
		endcase
	endfunction

	// A block is a string of runs of like samples, closed by the last-sample
	// mark, so pulses open, merge, split and flush at the block end.
	task automatic send_block();
		int len;
		int i;
		int kind;
		int run_len;
		int k;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 40);
		i = 0;
		while (i < len) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: kind = 0;
				4, 5, 6, 7: kind = 1;
				8:          kind = 2;
				default:    kind = 3;
			endcase
			run_len = $urandom_range(1, 6);
			for (int j = 0; j < run_len && i < len; j++) begin
				// a sample at the threshold now and then inside a run
				k = (kind == 0 && $urandom_range(0, 7) == 0) ? 2 : kind;
				push_sample(pick_sample(k), i == len - 1);
				i++;
			end
		end
	endtask

	// Main stimulus
	initial begin
		int phase_start;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = REG_THRESHOLD;
		cfg_data   = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tlast    = 1'b0;
		hold_req   = 1'b0;
		cur_thr    = 0;
		items_sent = 0;
		burst_left = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset defaults: threshold 0, gap 0, so every new run splits.
		push_sample(0, 0);	// at threshold: nothing starts
		push_sample(32767, 0);	// opens a pulse at the top value
		push_sample(32767, 0);	// equal peak: first one stays
		push_sample(5, 0);
		push_sample(0, 0);	// at threshold: run stays open
		push_sample(-1, 0);	// closes the run
		push_sample(0, 0);
		push_sample(100, 0);	// new run: reports the first pulse
		push_sample(-32768, 0);
		push_sample(200, 1);	// block end with an open run
		push_sample(9, 0);
		push_sample(-9, 0);
		push_sample(50, 1);	// new run on the block end: two results
		push_sample(-5, 1);	// block with no pulse
		push_sample(7, 0);
		push_sample(-7, 0);
		push_sample(0, 1);	// pending pulse flushed at block end

		// Merging across a short gap, shift above the honored maximum.
		settle();
		write_regs(-100, 65535, 2, 7, 65535);
		push_sample(50, 0);
		push_sample(-200, 0);
		push_sample(-200, 0);
		push_sample(60, 0);	// two samples after the end: merged, new peak
		push_sample(-200, 0);
		push_sample(-200, 0);
		push_sample(-200, 0);
		push_sample(70, 0);	// three after the end: splits
		push_sample(-32768, 1);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			settle();
			case (ph)
				0: write_regs(-32768, 0, 0, 0, 0);
				1: write_regs(32767, 65535, 16777215, 6, 65535);
				2: write_regs(32766, 1, 16777215, 1, 1);
				3: write_regs(0, 65535, 1, 7, $urandom_range(0, 65535));
				4: write_regs(0, 256, 0, 2, 12345);
				default: write_regs($urandom_range(0, 4000) - 2000, $urandom_range(0, 65535),
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
						: $urandom_range(0, 6),
					$urandom_range(0, 7), $urandom_range(0, 65535));
			endcase
			phase_start = items_sent;
			if (ph == 4) begin
				// receiver holds off while alternating samples pile up pulses
				hold_req = 1'b1;
				for (int n = 0; n < 80; n++)
					push_sample((n % 2 == 0) ? 1000 : -1000, n == 79);
			end
			while (items_sent - phase_start < PHASE_ITEMS)
				send_block();
		end

		settle();
		if (fail_count == 0 && awaiting == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Receiver: ready pattern changes mode at random; one long
	// hold-off on request.
	initial begin
		m_tready = 1'b0;
		rx_mode  = 0;
		rx_left  = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_mode = $urandom_range(0, 3);
					rx_left = $urandom_range(10, 80);
				end
				rx_left--;
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 7) == 0);
					default: m_tready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Watchdog: ends the run when no request moves for too long.
	initial begin
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				idle = 0;
			else
				idle++;
		end
		$display("TB_ERROR");
		$finish;
	end

endmodule
